[hw/rtl/dglcd_pkg.sv]
package dglcd_pkg;

  localparam int PAGES   = 8;
  localparam int COLUMNS = 64;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  // instruction codes in data bits 7:6
  localparam logic [1:0] INS_DISPLAY = 2'b00;
  localparam logic [1:0] INS_COLUMN  = 2'b01;
  localparam logic [1:0] INS_PAGE    = 2'b10;
  localparam logic [1:0] INS_START   = 2'b11;

  // configuration register indexes
  localparam logic REG_WRITE_BUSY = 1'b0;
  localparam logic REG_READ_BUSY  = 1'b1;

  localparam logic [15:0] WRITE_BUSY_RST = 16'd200;
  localparam logic [15:0] READ_BUSY_RST  = 16'd500;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  // reduce a 6-bit column value into range
  function automatic logic [COL_W-1:0] col_wrap(input logic [5:0] v);
    logic [COL_W-1:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (v == 6'(i)) r = COL_W'(i % COLUMNS);
    end
    return r;
  endfunction

  // reduce a 3-bit page value into range
  function automatic logic [PG_W-1:0] page_wrap(input logic [2:0] v);
    logic [PG_W-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (v == 3'(i)) r = PG_W'(i % PAGES);
    end
    return r;
  endfunction

  function automatic logic [COL_W-1:0] col_next(input logic [COL_W-1:0] c);
    return (c == COL_W'(COLUMNS - 1)) ? '0 : c + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [PG_W-1:0] pg,
                                                 input logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(pg) * ADDR_W'(COLUMNS) + ADDR_W'(col));
  endfunction

endpackage

[hw/rtl/dglcd_ram.sv]
module dglcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/dual_glcd_controller_top.sv]
// Two graphic display controllers sharing one host bus.
// Input channel (in_valid / in_stall): one item per bus access taken at the
// enable rising edge, or one microsecond tick when in_kind is 1.
// Result channel (out_valid / out_stall): exactly one item per input item,
// in order, carrying the driven bus byte, a drive flag and a dummy-read flag.
// The result is registered in the cycle after the item is accepted; a data
// read first passes through the ST_READ state for the display memory read.
// Throughput: one item per cycle unless out_stall holds a result; data reads
// also hold ST_READ: the one memory port per controller reads, then returns.
// Busy times are set through the APB-style port (write_busy_ticks at 0,
// read_busy_ticks at 4); write them only while the block is idle.
// After reset the two display memories are cleared in parallel, one entry per
// cycle, over all PAGES*COLUMNS (512) entries; in_stall stays high meanwhile.
// While out_stall holds a finished result, the next item is stalled until
// the result is taken.
module dual_glcd_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic        in_chip_select_one_n,
  input  logic        in_chip_select_two_n,
  input  logic        in_register_select,
  input  logic        in_read_not_write,
  input  logic [7:0]  in_data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_out,
  output logic        out_drives_bus,
  output logic        out_dummy_read,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dglcd_pkg::*;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [COL_W-1:0]  col_r [2];
  logic [COL_W-1:0]  col_nxt [2];
  logic [PG_W-1:0]   page_r [2];
  logic [PG_W-1:0]   page_nxt [2];
  logic [1:0]        on_r, on_nxt;
  logic [1:0]        pend_r, pend_nxt;
  logic [15:0]       busy_r [2];
  logic [15:0]       busy_nxt [2];
  logic [1:0]        rd_sel_r, rd_sel_nxt;
  logic              rd_dummy_r, rd_dummy_nxt;
  logic [15:0]       wr_ticks_r, rd_ticks_r;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_drive_r, out_drive_nxt;
  logic              out_dummy_r, out_dummy_nxt;

  logic              ram_we [2];
  logic [ADDR_W-1:0] ram_addr [2];
  logic [7:0]        ram_wdata [2];
  logic [7:0]        ram_rdata [2];

  logic       accept;
  logic [1:0] sel;
  logic [15:0] ticks;
  logic       cfg_wr;

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign sel      = {!in_chip_select_two_n, !in_chip_select_one_n};
  assign ticks    = in_read_not_write ? rd_ticks_r : wr_ticks_r;

  for (genvar g = 0; g < 2; g++) begin : g_mem
    dglcd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .addr  (ram_addr[g]),
      .wdata (ram_wdata[g]),
      .rdata (ram_rdata[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept && !in_kind && in_read_not_write && in_register_select) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    on_nxt        = on_r;
    pend_nxt      = pend_r;
    rd_sel_nxt    = rd_sel_r;
    rd_dummy_nxt  = rd_dummy_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_drive_nxt = out_drive_r;
    out_dummy_nxt = out_dummy_r;
    for (int c = 0; c < 2; c++) begin
      col_nxt[c]   = col_r[c];
      page_nxt[c]  = page_r[c];
      busy_nxt[c]  = busy_r[c];
      ram_we[c]    = 1'b0;
      ram_addr[c]  = mem_addr(page_r[c], col_r[c]);
      ram_wdata[c] = in_data_in;
    end

    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        for (int c = 0; c < 2; c++) begin
          ram_we[c]    = 1'b1;
          ram_addr[c]  = clr_cnt_r;
          ram_wdata[c] = '0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = !in_kind && in_read_not_write && in_register_select ? 1'b0 : 1'b1;
          out_data_nxt  = '0;
          out_drive_nxt = 1'b0;
          out_dummy_nxt = 1'b0;
          rd_sel_nxt    = '0;
          rd_dummy_nxt  = 1'b0;
          if (in_kind) begin
            for (int c = 0; c < 2; c++) begin
              if (busy_r[c] != '0) busy_nxt[c] = busy_r[c] - 1'b1;
            end
          end else begin
            if (!in_read_not_write) begin
              for (int c = 0; c < 2; c++) begin
                if (sel[c]) begin
                  pend_nxt[c] = 1'b1;
                  if (in_register_select) begin
                    ram_we[c]  = 1'b1;
                    col_nxt[c] = col_next(col_r[c]);
                  end else begin
                    unique case (in_data_in[7:6])
                      INS_COLUMN:  col_nxt[c]  = col_wrap(in_data_in[5:0]);
                      INS_PAGE:    page_nxt[c] = page_wrap(in_data_in[2:0]);
                      INS_DISPLAY: on_nxt[c]   = in_data_in[0];
                      INS_START:   ;  // start line only moves scan-out
                      default:     ;
                    endcase
                  end
                end
              end
            end else if (in_register_select) begin
              // data read: return through the memory in the next cycle
              for (int c = 0; c < 2; c++) begin
                if (sel[c]) begin
                  if (pend_r[c]) begin
                    pend_nxt[c]  = 1'b0;
                    rd_dummy_nxt = 1'b1;
                  end else begin
                    rd_sel_nxt[c] = 1'b1;
                    col_nxt[c]    = col_next(col_r[c]);
                  end
                end
              end
            end else begin
              out_drive_nxt = 1'b1;
              for (int c = 0; c < 2; c++) begin
                if (sel[c]) begin
                  out_data_nxt = {busy_r[c] != '0, 1'b0, on_r[c], 5'b0};
                end
              end
            end
            if (ticks != '0) begin
              for (int c = 0; c < 2; c++) begin
                if (sel[c]) busy_nxt[c] = ticks;
              end
            end
          end
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_drive_nxt = |rd_sel_r;
        out_dummy_nxt = rd_dummy_r;
        out_data_nxt  = rd_sel_r[1] ? ram_rdata[1] : (rd_sel_r[0] ? ram_rdata[0] : 8'h00);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      on_r        <= '0;
      pend_r      <= '0;
      rd_sel_r    <= '0;
      rd_dummy_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        col_r[c]  <= '0;
        page_r[c] <= '0;
        busy_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      on_r        <= on_nxt;
      pend_r      <= pend_nxt;
      rd_sel_r    <= rd_sel_nxt;
      rd_dummy_r  <= rd_dummy_nxt;
      out_valid_r <= out_valid_nxt;
      for (int c = 0; c < 2; c++) begin
        col_r[c]  <= col_nxt[c];
        page_r[c] <= page_nxt[c];
        busy_r[c] <= busy_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_drive_r <= out_drive_nxt;
    out_dummy_r <= out_dummy_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_drives_bus = out_drive_r;
  assign out_dummy_read = out_dummy_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ticks_r <= WRITE_BUSY_RST;
      rd_ticks_r <= READ_BUSY_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WRITE_BUSY) wr_ticks_r <= pwdata[15:0];
      if (paddr[2] == REG_READ_BUSY)  rd_ticks_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_READ_BUSY) ? {16'b0, rd_ticks_r} : {16'b0, wr_ticks_r};

endmodule

[tb/dual_glcd_checker.sv]
module dual_glcd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic        in_chip_select_one_n,
  input  logic        in_chip_select_two_n,
  input  logic        in_register_select,
  input  logic        in_read_not_write,
  input  logic [7:0]  in_data_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_data_out,
  input  logic        out_drives_bus,
  input  logic        out_dummy_read,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          results_left
);
  timeunit 1ns;
  timeprecision 1ps;
  import dglcd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       drive;
    logic       dummy;
  } bus_result_t;

  // shadow copy of both controllers
  logic [7:0]       panel_mem [2][DEPTH];
  logic [COL_W-1:0] col [2];
  logic [PG_W-1:0]  page [2];
  logic [5:0]       start_line [2];
  logic [1:0]       disp_on;
  logic [1:0]       dummy_armed;
  logic [15:0]      busy_left [2];
  logic [15:0]      wr_busy;
  logic [15:0]      rd_busy;

  bus_result_t bus_results[$];
  bus_result_t want;

  function automatic bus_result_t predict_bus(input logic kind, input logic cs1n,
                                              input logic cs2n, input logic rs,
                                              input logic rnw, input logic [7:0] d);
    bus_result_t r;
    logic [1:0]  sel;
    logic [15:0] t;
    int          a;
    r = '0;
    if (kind) begin
      for (int c = 0; c < 2; c++) begin
        if (busy_left[c] != 0) busy_left[c] = busy_left[c] - 1'b1;
      end
      return r;
    end
    sel = {~cs2n, ~cs1n};
    for (int c = 0; c < 2; c++) begin
      if (!sel[c]) continue;
      a = int'(page[c]) * COLUMNS + int'(col[c]);
      if (!rnw) begin
        dummy_armed[c] = 1'b1;
        if (rs) begin
          panel_mem[c][a] = d;
          col[c] = COL_W'((int'(col[c]) + 1) % COLUMNS);
        end else begin
          case (d[7:6])
            INS_COLUMN:  col[c] = COL_W'(int'(d[5:0]) % COLUMNS);
            INS_START:   start_line[c] = d[5:0];
            INS_PAGE:    page[c] = PG_W'(int'(d[2:0]) % PAGES);
            INS_DISPLAY: disp_on[c] = d[0];
          endcase
        end
      end else if (rs) begin
        // first data read after any write only clears the dummy flag and reports a dummy read
        if (dummy_armed[c]) begin
          dummy_armed[c] = 1'b0;
          r.dummy = 1'b1;
        end else begin
          r.data = panel_mem[c][a];
          r.drive = 1'b1;
          col[c] = COL_W'((int'(col[c]) + 1) % COLUMNS);
        end
      end else begin
        // second controller overwrites the first when both are selected
        r.data = {busy_left[c] != 0, 1'b0, disp_on[c], 5'b00000};
      end
    end
    if (rnw && !rs) r.drive = 1'b1;
    t = rnw ? rd_busy : wr_busy;
    if (t != 0) begin
      for (int c = 0; c < 2; c++) begin
        if (sel[c]) busy_left[c] = t;
      end
    end
    return r;
  endfunction

  initial begin
    mismatches = 0;
    results_left = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < DEPTH; i++) panel_mem[c][i] = 8'h00;
        col[c] = '0;
        page[c] = '0;
        start_line[c] = '0;
        busy_left[c] = '0;
      end
      disp_on = '0;
      dummy_armed = '0;
      wr_busy = WRITE_BUSY_RST;
      rd_busy = READ_BUSY_RST;
      bus_results.delete();
    end else begin
      // the result of an item accepted now can't appear at this edge
      if (out_valid && !out_stall) begin
        if (bus_results.size() == 0) begin
          $error("result with nothing expected: data_out %02h drives_bus %0b dummy_read %0b",
                 out_data_out, out_drives_bus, out_dummy_read);
          mismatches++;
        end else begin
          want = bus_results.pop_front();
          if (out_data_out !== want.data) begin
            $error("data_out mismatch: expected %02h, got %02h", want.data, out_data_out);
            mismatches++;
          end
          if (out_drives_bus !== want.drive) begin
            $error("drives_bus mismatch: expected %0b, got %0b", want.drive, out_drives_bus);
            mismatches++;
          end
          if (out_dummy_read !== want.dummy) begin
            $error("dummy_read mismatch: expected %0b, got %0b", want.dummy, out_dummy_read);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        bus_results.push_back(predict_bus(in_kind, in_chip_select_one_n,
                                          in_chip_select_two_n, in_register_select,
                                          in_read_not_write, in_data_in));
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WRITE_BUSY) wr_busy = pwdata[15:0];
        else rd_busy = pwdata[15:0];
      end
    end
    results_left = bus_results.size();
  end

endmodule

[tb/dual_glcd_controller_top_tb.sv]
module dual_glcd_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dglcd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 300;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 100;

  // active-low select patterns {cs_two_n, cs_one_n}
  localparam logic [1:0] SEL_ONE  = 2'b10;
  localparam logic [1:0] SEL_TWO  = 2'b01;
  localparam logic [1:0] SEL_BOTH = 2'b00;
  localparam logic [1:0] SEL_NONE = 2'b11;

  typedef struct packed {
    logic       kind;
    logic       cs1n;
    logic       cs2n;
    logic       rs;
    logic       rnw;
    logic [7:0] data;
  } bus_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic        in_chip_select_one_n;
  logic        in_chip_select_two_n;
  logic        in_register_select;
  logic        in_read_not_write;
  logic [7:0]  in_data_in;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_data_out;
  logic        out_drives_bus;
  logic        out_dummy_read;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          results_left;
  int          items_sent;
  int          burst_left;
  int          idle_cycles;
  int          phase_start;
  int          stall_mode;
  int          mode_left;
  logic        hold_req;
  logic [15:0] wr_ticks [NUM_PHASES];
  logic [15:0] rd_ticks [NUM_PHASES];

  dual_glcd_controller_top u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_chip_select_one_n (in_chip_select_one_n),
    .in_chip_select_two_n (in_chip_select_two_n),
    .in_register_select   (in_register_select),
    .in_read_not_write    (in_read_not_write),
    .in_data_in           (in_data_in),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_data_out         (out_data_out),
    .out_drives_bus       (out_drives_bus),
    .out_dummy_read       (out_dummy_read),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  dual_glcd_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_chip_select_one_n (in_chip_select_one_n),
    .in_chip_select_two_n (in_chip_select_two_n),
    .in_register_select   (in_register_select),
    .in_read_not_write    (in_read_not_write),
    .in_data_in           (in_data_in),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_data_out         (out_data_out),
    .out_drives_bus       (out_drives_bus),
    .out_dummy_read       (out_dummy_read),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .pready               (pready),
    .mismatches           (mismatches),
    .results_left         (results_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bus_item_t access(input logic [1:0] sel_n, input logic rs,
                                       input logic rnw, input logic [7:0] d);
    bus_item_t it;
    it.kind = 1'b0;
    it.cs1n = sel_n[0];
    it.cs2n = sel_n[1];
    it.rs = rs;
    it.rnw = rnw;
    it.data = d;
    return it;
  endfunction

  // other fields are don't-care on a tick, so randomize them
  function automatic bus_item_t tick_item();
    bus_item_t it;
    it = 13'($urandom);
    it.kind = 1'b1;
    return it;
  endfunction

  task automatic send(input bus_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid             <= 1'b1;
    in_kind              <= it.kind;
    in_chip_select_one_n <= it.cs1n;
    in_chip_select_two_n <= it.cs2n;
    in_register_select   <= it.rs;
    in_read_not_write    <= it.rnw;
    in_data_in           <= it.data;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait (results_left == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // set display or start line, position, write a run of bytes, reposition, read them back, tick, then read status
  task automatic frame_burst();
    logic [1:0] sel;
    logic [5:0] c0;
    logic [2:0] pg;
    int         k;
    int         n;
    k = $urandom_range(0, 9);
    sel = (k < 4) ? SEL_ONE : (k < 7) ? SEL_TWO : (k < 9) ? SEL_BOTH : SEL_NONE;
    n = $urandom_range(1, 8);
    c0 = 6'($urandom);
    pg = 3'($urandom);
    if ($urandom_range(0, 1)) send(access(sel, 1'b0, 1'b0, {INS_DISPLAY, 6'($urandom)}));
    else send(access(sel, 1'b0, 1'b0, {INS_START, 6'($urandom)}));
    send(access(sel, 1'b0, 1'b0, {INS_PAGE, 3'($urandom), pg}));
    send(access(sel, 1'b0, 1'b0, {INS_COLUMN, c0}));
    repeat (n) send(access(sel, 1'b1, 1'b0, 8'($urandom)));
    send(access(sel, 1'b0, 1'b0, {INS_COLUMN, c0}));
    repeat (n + 1) send(access(sel, 1'b1, 1'b1, 8'($urandom)));
    repeat ($urandom_range(0, 6)) send(tick_item());
    send(access(sel, 1'b0, 1'b1, 8'($urandom)));
  endtask

  // receiver: random stall pattern, or one long hold when asked
  initial begin
    out_stall = 1'b0;
    mode_left = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((mode_left % 8) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_chip_select_one_n = 1'b1;
    in_chip_select_two_n = 1'b1;
    in_register_select = 1'b0;
    in_read_not_write = 1'b0;
    in_data_in = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 1'b0;
    items_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    wr_ticks = '{16'd0, 16'hFFFF, 16'd1, 16'd5, 16'($urandom_range(0, 12)), WRITE_BUSY_RST};
    rd_ticks = '{16'd0, 16'hFFFF, 16'd3, 16'd2, 16'($urandom_range(0, 12)), READ_BUSY_RST};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pass at reset busy times
    send(access(SEL_NONE, 1'b0, 1'b1, 8'h00));
    send(access(SEL_ONE,  1'b0, 1'b1, 8'hFF));
    send(access(SEL_BOTH, 1'b1, 1'b1, 8'h00));
    send(access(SEL_BOTH, 1'b0, 1'b0, {INS_DISPLAY, 6'h3F}));
    send(access(SEL_TWO,  1'b0, 1'b1, 8'h00));
    send(tick_item());
    send(access(SEL_BOTH, 1'b0, 1'b0, {INS_PAGE, 6'h3F}));
    send(access(SEL_BOTH, 1'b0, 1'b0, {INS_COLUMN, 6'h3F}));
    send(access(SEL_BOTH, 1'b0, 1'b0, {INS_START, 6'h3F}));
    send(access(SEL_BOTH, 1'b1, 1'b0, 8'hFF));
    send(access(SEL_ONE,  1'b1, 1'b0, 8'h55));
    send(access(SEL_ONE,  1'b0, 1'b0, {INS_COLUMN, 6'h00}));
    send(access(SEL_ONE,  1'b1, 1'b1, 8'h00));
    send(access(SEL_ONE,  1'b1, 1'b1, 8'hFF));
    send(access(SEL_BOTH, 1'b1, 1'b1, 8'h00));
    send(access(SEL_NONE, 1'b1, 1'b1, 8'h00));
    send(access(SEL_NONE, 1'b1, 1'b0, 8'hAA));
    send(access(SEL_TWO,  1'b0, 1'b0, {INS_DISPLAY, 6'h3E}));
    send(access(SEL_BOTH, 1'b0, 1'b1, 8'h00));
    send(tick_item());
    send(access(SEL_TWO,  1'b1, 1'b1, 8'h00));
    send(access(SEL_TWO,  1'b1, 1'b1, 8'h00));
    send(access(SEL_ONE,  1'b0, 1'b0, {INS_PAGE, 6'h38}));
    send(access(SEL_ONE,  1'b1, 1'b1, 8'h00));

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(REG_WRITE_BUSY, wr_ticks[p]);
      write_reg(REG_READ_BUSY, rd_ticks[p]);
      // keep offering items while the receiver holds off
      if (p == 1) hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 70) frame_burst();
        else send(13'($urandom));
      end
    end
    settle();

    $display("covered %0d items over %0d busy-time settings, incl. zero and maximum",
             items_sent, NUM_PHASES + 1);
    $display("with one long result hold-off and random stalls on both sides");
    if (results_left != 0) $error("%0d expected results never arrived", results_left);
    if (mismatches == 0 && results_left == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/dglcd_pkg.sv
hw/rtl/dglcd_ram.sv
hw/rtl/dual_glcd_controller_top.sv
tb/dual_glcd_checker.sv
tb/dual_glcd_controller_top_tb.sv
